// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define KSFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define KSFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ksfp_pkg.sv =====
// Constants and types for the key state frame parser.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ksfp_pkg;

   localparam int BYTE_W            = 8;
   localparam int ROW_W             = 7;
   localparam int OUT_ROWS          = 6;
   localparam int ROW_COUNT_DEFAULT = 6;
   localparam int COL_COUNT_DEFAULT = 7;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ROW_W-1:0]  row_type;

   localparam byte_type START_MARK = 8'hAA;
   localparam byte_type END_MARK   = 8'h55;

endpackage

// ===== rtl/key_state_frame_parser.sv =====
// Key state frame parser: finds start/end delimited frames with an XOR checksum.
// Depends on ksfp_pkg.
`timescale 1ns / 1ps

// Takes one received byte per transaction and looks for frames of ROW_COUNT + 3
// bytes: 0xAA, ROW_COUNT row bytes, the XOR of the row bytes, 0x55. The last
// ROW_COUNT + 2 unconsumed bytes are held in a shift window. When a byte arrives
// with the window full and the oldest byte is 0xAA and the new one 0x55, the
// frame is consumed and one result transaction carries the six row bitmaps (low
// COL_COUNT bits of each row, all zero on a checksum mismatch) and checksum_ok;
// otherwise the oldest byte is dropped. The checksum and marker compare sit
// between the window registers and the result register, and a new byte is
// taken every cycle unless a result waits under stall. A result appears in the
// cycle after the byte that closes its frame is taken.

module key_state_frame_parser
   import ksfp_pkg::*;
#(
   parameter int ROW_COUNT = ROW_COUNT_DEFAULT,
   parameter int COL_COUNT = COL_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ROW_W-1:0]    rsp_row0_keys,
   output logic [ROW_W-1:0]    rsp_row1_keys,
   output logic [ROW_W-1:0]    rsp_row2_keys,
   output logic [ROW_W-1:0]    rsp_row3_keys,
   output logic [ROW_W-1:0]    rsp_row4_keys,
   output logic [ROW_W-1:0]    rsp_row5_keys,
   output logic                rsp_checksum_ok
);

   localparam int HOLD_LEN = ROW_COUNT + 2;
   localparam int FILL_W   = $clog2(HOLD_LEN + 1);
   localparam logic [BYTE_W:0] COL_MASK_W = (BYTE_W+1)'((1 << COL_COUNT) - 1);
   localparam row_type COL_MASK = COL_MASK_W[ROW_W-1:0];

   byte_type            window_ff [HOLD_LEN];
   byte_type            window_in [HOLD_LEN];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   row_type             rows_ff [OUT_ROWS];
   row_type             rows_in [OUT_ROWS];
   logic                ok_ff;

   logic      accept;
   logic      full;
   logic      hit;
   logic      ok;
   byte_type  chk;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == FILL_W'(HOLD_LEN));
   assign hit       = full && (window_ff[0] == START_MARK) && (req_rx_byte == END_MARK);

   always_comb begin
      chk = '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
         chk = chk ^ window_ff[1 + r];
      end
   end
   assign ok = (chk == window_ff[ROW_COUNT + 1]);

   for (genvar r = 0; r < OUT_ROWS; r++) begin : g_row
      if (r < ROW_COUNT) begin : g_used
         assign rows_in[r] = ok ? (window_ff[1 + r][ROW_W-1:0] & COL_MASK) : '0;
      end else begin : g_unused
         assign rows_in[r] = '0;
      end
   end

   // Window shifts on every accepted byte; once full, entry 0 is the oldest byte.
   always_comb begin
      for (int i = 0; i < HOLD_LEN - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[HOLD_LEN-1] = req_rx_byte;
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (!full) begin
            fill_in = fill_ff + FILL_W'(1);
         end else if (hit) begin
            fill_in = '0;
         end
      end
   end

   assign rsp_valid_in = accept ? hit : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
      if (accept && hit) begin
         rows_ff <= rows_in;
         ok_ff   <= ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row0_keys   = rows_ff[0];
   assign rsp_row1_keys   = rows_ff[1];
   assign rsp_row2_keys   = rows_ff[2];
   assign rsp_row3_keys   = rows_ff[3];
   assign rsp_row4_keys   = rows_ff[4];
   assign rsp_row5_keys   = rows_ff[5];
   assign rsp_checksum_ok = ok_ff;

endmodule

// ===== rtl/ksfp_checker.sv =====
// Port-level checker for the key state frame parser, bound to the top level.
// Depends on ksfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ksfp_checker
   import ksfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [ROW_W-1:0]  rsp_row0_keys,
   input  logic [ROW_W-1:0]  rsp_row1_keys,
   input  logic [ROW_W-1:0]  rsp_row2_keys,
   input  logic [ROW_W-1:0]  rsp_row3_keys,
   input  logic [ROW_W-1:0]  rsp_row4_keys,
   input  logic [ROW_W-1:0]  rsp_row5_keys,
   input  logic              rsp_checksum_ok
);

   logic rows_zero;
   assign rows_zero = (rsp_row0_keys == '0) && (rsp_row1_keys == '0) &&
                      (rsp_row2_keys == '0) && (rsp_row3_keys == '0) &&
                      (rsp_row4_keys == '0) && (rsp_row5_keys == '0);

   `KSFP_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")
   `KSFP_ASSERT(a_bad_sum_zero, (rsp_valid && !rsp_checksum_ok) |-> rows_zero, "rows not cleared on checksum mismatch")
   `KSFP_ASSERT(a_new_needs_req, (rsp_valid && !$past(rsp_valid && rsp_stall)) |-> $past(req_valid && !req_stall), "result without a closing byte")
   `KSFP_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_checksum_ok) && $stable(rsp_row0_keys)), "stalled result changed")

endmodule

bind key_state_frame_parser ksfp_checker u_ksfp_checker (.*);

// ===== tb/key_state_frame_parser_tb.sv =====
// Self-checking testbench for key_state_frame_parser: directed frames, then random
// framed and broken byte streams under random gaps and result stalls.
// Depends on ksfp_pkg and the key_state_frame_parser RTL.
`timescale 1ns / 1ps

module key_state_frame_parser_tb
   import ksfp_pkg::*;
();

   localparam int       ROWS         = ROW_COUNT_DEFAULT;
   localparam int       HOLD_LEN     = ROWS + 2;
   localparam byte_type COL_MASK     = byte_type'((1 << COL_COUNT_DEFAULT) - 1);
   localparam int       RANDOM_BYTES = 1350;
   localparam int       DIR_LEN      = 28;

   typedef struct packed {
      row_type row0;
      row_type row1;
      row_type row2;
      row_type row3;
      row_type row4;
      row_type row5;
      logic    checksum_ok;
   } key_frame_type;

   typedef struct packed {
      byte_type      data;
      logic          has_exp;
      key_frame_type exp;
   } stim_row_type;

   localparam key_frame_type NO_FRAME = '0;

   localparam stim_row_type DIRECTED [DIR_LEN] = '{
      // good frame, row bytes at the extremes, bit 7 cleared on output
      '{START_MARK, 1'b0, NO_FRAME},
      '{8'hFF, 1'b0, NO_FRAME},
      '{8'h80, 1'b0, NO_FRAME},
      '{8'h00, 1'b0, NO_FRAME},
      '{8'h7F, 1'b0, NO_FRAME},
      '{8'h01, 1'b0, NO_FRAME},
      '{8'hFE, 1'b0, NO_FRAME},
      '{8'hFF, 1'b0, NO_FRAME},
      '{END_MARK, 1'b1, '{7'h7F, 7'h00, 7'h00, 7'h7F, 7'h01, 7'h7E, 1'b1}},
      // checksum mismatch: consumed, rows all zero
      '{START_MARK, 1'b0, NO_FRAME},
      '{8'h11, 1'b0, NO_FRAME},
      '{8'h22, 1'b0, NO_FRAME},
      '{8'h33, 1'b0, NO_FRAME},
      '{8'h44, 1'b0, NO_FRAME},
      '{8'h55, 1'b0, NO_FRAME},
      '{8'h66, 1'b0, NO_FRAME},
      '{8'h00, 1'b0, NO_FRAME},
      '{END_MARK, 1'b1, '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 1'b0}},
      // stray start marker ahead of a frame: oldest byte dropped, then resync
      '{START_MARK, 1'b0, NO_FRAME},
      '{START_MARK, 1'b0, NO_FRAME},
      '{8'h12, 1'b0, NO_FRAME},
      '{8'h34, 1'b0, NO_FRAME},
      '{8'h56, 1'b0, NO_FRAME},
      '{8'h78, 1'b0, NO_FRAME},
      '{8'h9A, 1'b0, NO_FRAME},
      '{8'hBC, 1'b0, NO_FRAME},
      '{8'h2E, 1'b0, NO_FRAME},
      '{END_MARK, 1'b0, NO_FRAME}
   };

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   byte_type req_rx_byte = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   row_type  rsp_row0_keys;
   row_type  rsp_row1_keys;
   row_type  rsp_row2_keys;
   row_type  rsp_row3_keys;
   row_type  rsp_row4_keys;
   row_type  rsp_row5_keys;
   logic     rsp_checksum_ok;

   key_frame_type pending_frames [$];
   byte_type      window [HOLD_LEN];
   int unsigned   held = 0;
   int unsigned   bytes_sent = 0;
   int unsigned   frames_seen = 0;
   int unsigned   frames_good = 0;
   int unsigned   frames_bad = 0;
   int unsigned   mismatches = 0;
   bit            calm = 1'b0;

   key_state_frame_parser u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row0_keys  (rsp_row0_keys),
      .rsp_row1_keys  (rsp_row1_keys),
      .rsp_row2_keys  (rsp_row2_keys),
      .rsp_row3_keys  (rsp_row3_keys),
      .rsp_row4_keys  (rsp_row4_keys),
      .rsp_row5_keys  (rsp_row5_keys),
      .rsp_checksum_ok(rsp_checksum_ok)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("key_state_frame_parser verification failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Window model: returns 1 when the byte closes a frame.
   function automatic bit parse_byte(input byte_type b, output key_frame_type frame);
      byte_type chk;
      row_type  keys [OUT_ROWS];
      logic     ok;
      frame = NO_FRAME;
      if (held < HOLD_LEN) begin
         window[held] = b;
         held++;
         return 1'b0;
      end
      if (window[0] != START_MARK || b != END_MARK) begin
         for (int i = 1; i < HOLD_LEN; i++)
            window[i-1] = window[i];
         window[HOLD_LEN-1] = b;
         return 1'b0;
      end
      chk = '0;
      for (int r = 0; r < ROWS; r++)
         chk ^= window[1+r];
      ok = (chk == window[1+ROWS]);
      for (int r = 0; r < OUT_ROWS; r++)
         keys[r] = (ok && r < ROWS) ? row_type'(window[1+r] & COL_MASK) : '0;
      frame = '{keys[0], keys[1], keys[2], keys[3], keys[4], keys[5], ok};
      if (ok)
         frames_good++;
      else
         frames_bad++;
      held = 0;
      return 1'b1;
   endfunction

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $time, msg);
   endtask

   task automatic send_byte(input byte_type data, input logic typed,
                            input key_frame_type typed_exp);
      int unsigned   gap;
      key_frame_type pred;
      bit            hit;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      hit = parse_byte(data, pred);
      if (typed)
         pending_frames.push_back(typed_exp);
      else if (hit)
         pending_frames.push_back(pred);
   endtask

   always @(posedge clock) begin : rsp_check
      key_frame_type got;
      key_frame_type want;
      got = '{rsp_row0_keys, rsp_row1_keys, rsp_row2_keys, rsp_row3_keys,
              rsp_row4_keys, rsp_row5_keys, rsp_checksum_ok};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            flag($sformatf("unexpected result transaction: rows %h %h %h %h %h %h ok %b",
                           got.row0, got.row1, got.row2, got.row3, got.row4, got.row5,
                           got.checksum_ok));
         end else begin
            want = pending_frames.pop_front();
            frames_seen++;
            if (got !== want)
               flag($sformatf({"frame %0d: exp rows %h %h %h %h %h %h ok %b,",
                               " got rows %h %h %h %h %h %h ok %b"}, frames_seen,
                              want.row0, want.row1, want.row2, want.row3, want.row4,
                              want.row5, want.checksum_ok, got.row0, got.row1, got.row2,
                              got.row3, got.row4, got.row5, got.checksum_ok));
         end
      end
   end

   initial begin : stall_gen
      int unsigned n;
      @(negedge reset);
      forever begin
         n = pick_gap();
         rsp_stall <= (n != 0);
         repeat (n == 0 ? $urandom_range(1, 4) : n) @(posedge clock);
      end
   end

   initial begin : main_seq
      byte_type    burst [$];
      byte_type    chk;
      byte_type    b;
      int unsigned kind;
      int unsigned pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_byte(DIRECTED[i].data, DIRECTED[i].has_exp, DIRECTED[i].exp);

      while (bytes_sent < DIR_LEN + RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0)
            calm = ~calm;
         kind = $urandom_range(0, 99);
         burst.delete();
         if (kind < 8) begin
            repeat ($urandom_range(1, 12)) burst.push_back(byte_type'($urandom));
         end else begin
            chk = '0;
            burst.push_back(START_MARK);
            repeat (ROWS) begin
               pick = $urandom_range(0, 15);
               case (pick)
                  0:       b = START_MARK;
                  1:       b = END_MARK;
                  2:       b = 8'hFF;
                  3:       b = 8'h00;
                  default: b = byte_type'($urandom);
               endcase
               chk ^= b;
               burst.push_back(b);
            end
            if (kind < 18)
               chk ^= byte_type'($urandom_range(1, 255));
            burst.push_back(chk);
            burst.push_back(END_MARK);
            if (kind >= 18 && kind < 26)
               burst = burst[0:$urandom_range(0, HOLD_LEN - 1)];
            else if (kind >= 26 && kind < 34)
               repeat ($urandom_range(1, 4)) burst.push_front(byte_type'($urandom));
         end
         foreach (burst[i])
            send_byte(burst[i], 1'b0, NO_FRAME);
      end
      req_valid <= 1'b0;

      while (pending_frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes; %0d frames decoded (%0d good checksum, %0d bad), %0d mismatches",
               bytes_sent, frames_seen, frames_good, frames_bad, mismatches);
      if (mismatches == 0)
         $display("key_state_frame_parser verification clean");
      else
         $display("key_state_frame_parser verification failed");
      $finish;
   end

endmodule
